// ===== design/pal_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pal_pkg
// Shared types, codes and the control store for the positional array list.
// ----------------------------------------------------------------------------
package pal_pkg;

  // command codes on the input beat
  typedef enum logic [1:0] {
    CMD_GET    = 2'd0,
    CMD_LOCATE = 2'd1,
    CMD_INSERT = 2'd2,
    CMD_DELETE = 2'd3
  } cmd_t;

  // micro program counter
  typedef logic [3:0] upc_t;

  // entry points of the micro program
  localparam upc_t ST_GET = 4'd0;
  localparam upc_t ST_LOC = 4'd2;
  localparam upc_t ST_LOC_TEST = 4'd3;
  localparam upc_t ST_LOC_HIT = 4'd5;
  localparam upc_t ST_INS = 4'd6;
  localparam upc_t ST_INS_TEST = 4'd7;
  localparam upc_t ST_INS_PUT = 4'd9;
  localparam upc_t ST_DEL = 4'd10;
  localparam upc_t ST_DEL_TEST = 4'd11;
  localparam upc_t ST_DEL_END = 4'd13;
  localparam upc_t ST_ERR = 4'd14;
  localparam upc_t ST_OK = 4'd15;

  // jump conditions
  typedef enum logic [2:0] {
    C_NEXT     = 3'd0,
    C_ALWAYS   = 3'd1,
    C_GET_BAD  = 3'd2,
    C_INS_BAD  = 3'd3,
    C_K_GE_LEN = 3'd4,
    C_K_LT_POS = 3'd5,
    C_NO_MATCH = 3'd6
  } cond_t;

  // read address source
  typedef enum logic [1:0] {
    RD_POS = 2'd0,
    RD_K   = 2'd1,
    RD_KM1 = 2'd2
  } rd_sel_t;

  // write address and data source
  typedef enum logic [1:0] {
    WR_NONE     = 2'd0,
    WR_K_MOVE   = 2'd1,
    WR_KM1_MOVE = 2'd2,
    WR_K_ITEM   = 2'd3
  } wr_sel_t;

  // index register operation
  typedef enum logic [2:0] {
    K_HOLD = 3'd0,
    K_ZERO = 3'd1,
    K_LEN  = 3'd2,
    K_POS  = 3'd3,
    K_INC  = 3'd4,
    K_DEC  = 3'd5
  } k_op_t;

  // length register operation
  typedef enum logic [1:0] {
    L_HOLD = 2'd0,
    L_INC  = 2'd1,
    L_DEC  = 2'd2
  } len_op_t;

  // one control word
  typedef struct packed {
    cond_t   cond;
    upc_t    target;
    rd_sel_t rd;
    wr_sel_t wr;
    k_op_t   kop;
    len_op_t lop;
    logic    cap_rd;
    logic    set_found;
    logic    set_err;
    logic    fin;
  } ctrl_t;

  // datapath status seen by the sequencer
  typedef struct packed {
    logic get_bad;
    logic ins_bad;
    logic k_ge_len;
    logic k_lt_pos;
    logic match;
  } flags_t;

  // dispatch table
  function automatic upc_t entry_of(cmd_t c);
    upc_t a;
    unique case (c)
      CMD_GET:    a = ST_GET;
      CMD_LOCATE: a = ST_LOC;
      CMD_INSERT: a = ST_INS;
      CMD_DELETE: a = ST_DEL;
      default:    a = ST_ERR;
    endcase
    return a;
  endfunction

  // control store
  function automatic ctrl_t microcode(upc_t a);
    ctrl_t cw;
    cw = '0;
    unique case (a)
      // get: check and read, then capture
      4'd0: begin
        cw.cond = C_GET_BAD; cw.target = ST_ERR; cw.rd = RD_POS;
      end
      4'd1: begin
        cw.cap_rd = 1'b1; cw.fin = 1'b1;
      end
      // locate: walk from the front, one read and one compare per entry
      4'd2: begin
        cw.kop = K_ZERO;
      end
      4'd3: begin
        cw.cond = C_K_GE_LEN; cw.target = ST_OK; cw.rd = RD_K;
      end
      4'd4: begin
        cw.cond = C_NO_MATCH; cw.target = ST_LOC_TEST; cw.kop = K_INC;
      end
      4'd5: begin
        cw.set_found = 1'b1; cw.fin = 1'b1;
      end
      // insert: shift entries up from the tail, then place the new one
      4'd6: begin
        cw.cond = C_INS_BAD; cw.target = ST_ERR; cw.kop = K_LEN;
      end
      4'd7: begin
        cw.cond = C_K_LT_POS; cw.target = ST_INS_PUT; cw.rd = RD_KM1;
      end
      4'd8: begin
        cw.cond = C_ALWAYS; cw.target = ST_INS_TEST; cw.wr = WR_K_MOVE; cw.kop = K_DEC;
      end
      4'd9: begin
        cw.wr = WR_K_ITEM; cw.lop = L_INC; cw.fin = 1'b1;
      end
      // delete: shift entries down past the position
      4'd10: begin
        cw.cond = C_GET_BAD; cw.target = ST_ERR; cw.kop = K_POS;
      end
      4'd11: begin
        cw.cond = C_K_GE_LEN; cw.target = ST_DEL_END; cw.rd = RD_K;
      end
      4'd12: begin
        cw.cond = C_ALWAYS; cw.target = ST_DEL_TEST; cw.wr = WR_KM1_MOVE; cw.kop = K_INC;
      end
      4'd13: begin
        cw.lop = L_DEC; cw.fin = 1'b1;
      end
      // error exit
      4'd14: begin
        cw.set_err = 1'b1; cw.fin = 1'b1;
      end
      default: begin
        cw.fin = 1'b1;
      end
    endcase
    return cw;
  endfunction

endpackage

// ===== design/pal_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pal_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module pal_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic [AW-1:0]        raddr,
  output logic [WIDTH-1:0]     rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/pal_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pal_seq
// Micro sequencer: step counter, control store lookup and conditional jumps.
// ----------------------------------------------------------------------------
module pal_seq (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [1:0]       command,
  input  pal_pkg::flags_t  flags,
  output logic             launch,
  output pal_pkg::ctrl_t   ctrl,
  output logic             busy,
  output logic             done
);
  pal_pkg::upc_t upc;
  pal_pkg::upc_t upc_next;
  logic          busy_next;
  logic          done_next;
  logic          taken;

  // accept a beat when idle
  assign launch = start && !busy;

  // current control word, quiet while idle
  always_comb begin
    ctrl = busy ? pal_pkg::microcode(upc) : '0;
  end

  // jump condition select
  always_comb begin
    unique case (ctrl.cond)
      pal_pkg::C_NEXT:     taken = 1'b0;
      pal_pkg::C_ALWAYS:   taken = 1'b1;
      pal_pkg::C_GET_BAD:  taken = flags.get_bad;
      pal_pkg::C_INS_BAD:  taken = flags.ins_bad;
      pal_pkg::C_K_GE_LEN: taken = flags.k_ge_len;
      pal_pkg::C_K_LT_POS: taken = flags.k_lt_pos;
      pal_pkg::C_NO_MATCH: taken = !flags.match;
      default:             taken = 1'b0;
    endcase
  end

  // next step
  always_comb begin
    if (launch) begin
      upc_next = pal_pkg::entry_of(pal_pkg::cmd_t'(command));
    end else if (taken) begin
      upc_next = ctrl.target;
    end else begin
      upc_next = upc + 4'd1;
    end
    busy_next = launch ? 1'b1 : (busy && !ctrl.fin);
    done_next = busy && ctrl.fin;
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      upc  <= pal_pkg::ST_GET;
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      upc  <= upc_next;
      busy <= busy_next;
      done <= done_next;
    end
  end

  // the result strobe always lands after the work, never during it
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  // an accepted beat starts the program
  a_launch_busy: assert property (@(posedge clk) disable iff (rst) launch |=> busy)
    else $error("accepted beat did not start the sequencer");

  // a strobe follows only a finishing step
  a_done_fin: assert property (@(posedge clk) disable iff (rst)
      done |-> $past(busy) && $past(ctrl.fin))
    else $error("result strobe without a finishing step");

endmodule

// ===== design/pal_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pal_datapath
// Index and length registers, element stores and result registers, driven
// one control word at a time.
// ----------------------------------------------------------------------------
module pal_datapath #(
  parameter int CAPACITY = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             launch,
  input  pal_pkg::ctrl_t   ctrl,
  input  logic [6:0]       op_position,
  input  logic [31:0]      op_price,
  input  logic [63:0]      op_tag,
  output pal_pkg::flags_t  flags,
  output logic             status,
  output logic [6:0]       found_position,
  output logic [31:0]      out_price,
  output logic [63:0]      out_tag,
  output logic [6:0]       list_count
);
  localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LW   = $clog2(CAPACITY + 1);
  localparam int CMPW = ((LW > 7) ? LW : 7) + 1;

  logic [LW-1:0]   k;
  logic [LW-1:0]   k_next;
  logic [LW-1:0]   len;
  logic [LW-1:0]   len_next;
  logic [LW-1:0]   k_m1;
  logic [6:0]      pos_m1;
  logic [CMPW-1:0] pos_x;
  logic [CMPW-1:0] len_x;
  logic [CMPW-1:0] k_x;
  logic [AW-1:0]   raddr;
  logic [AW-1:0]   waddr;
  logic            we;
  logic [31:0]     wprice;
  logic [63:0]     wtag;
  logic [31:0]     rprice;
  logic [63:0]     rtag;

  // widened operands for compares
  assign pos_x  = CMPW'(op_position);
  assign len_x  = CMPW'(len);
  assign k_x    = CMPW'(k);
  assign k_m1   = k - LW'(1);
  assign pos_m1 = op_position - 7'd1;

  // status toward the sequencer
  always_comb begin
    flags.get_bad  = (pos_x == '0) || (pos_x > len_x);
    flags.ins_bad  = (pos_x == '0) || (pos_x > len_x + CMPW'(1)) ||
                     (len_x >= CMPW'(CAPACITY));
    flags.k_ge_len = (k >= len);
    flags.k_lt_pos = (k_x < pos_x);
    flags.match    = (rprice == op_price);
  end

  // read address select
  always_comb begin
    unique case (ctrl.rd)
      pal_pkg::RD_POS: raddr = AW'(pos_m1);
      pal_pkg::RD_K:   raddr = AW'(k);
      pal_pkg::RD_KM1: raddr = AW'(k_m1);
      default:         raddr = AW'(k);
    endcase
  end

  // write address and data select
  always_comb begin
    we     = 1'b1;
    waddr  = AW'(k);
    wprice = rprice;
    wtag   = rtag;
    unique case (ctrl.wr)
      pal_pkg::WR_NONE:     we = 1'b0;
      pal_pkg::WR_K_MOVE:   waddr = AW'(k);
      pal_pkg::WR_KM1_MOVE: waddr = AW'(k_m1);
      pal_pkg::WR_K_ITEM: begin
        wprice = op_price;
        wtag   = op_tag;
      end
      default:              we = 1'b0;
    endcase
  end

  // index and length updates
  always_comb begin
    unique case (ctrl.kop)
      pal_pkg::K_HOLD: k_next = k;
      pal_pkg::K_ZERO: k_next = '0;
      pal_pkg::K_LEN:  k_next = len;
      pal_pkg::K_POS:  k_next = LW'(op_position);
      pal_pkg::K_INC:  k_next = k + LW'(1);
      pal_pkg::K_DEC:  k_next = k_m1;
      default:         k_next = k;
    endcase
    unique case (ctrl.lop)
      pal_pkg::L_HOLD: len_next = len;
      pal_pkg::L_INC:  len_next = len + LW'(1);
      pal_pkg::L_DEC:  len_next = len - LW'(1);
      default:         len_next = len;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      len <= '0;
    end else begin
      len <= len_next;
    end
  end

  // working index and result registers
  always_ff @(posedge clk) begin
    k <= k_next;
    if (rst || launch) begin
      status         <= 1'b0;
      found_position <= '0;
      out_price      <= '0;
      out_tag        <= '0;
    end else begin
      if (ctrl.set_err) begin
        status <= 1'b1;
      end
      if (ctrl.set_found) begin
        found_position <= 7'(k);
      end
      if (ctrl.cap_rd) begin
        out_price <= rprice;
        out_tag   <= rtag;
      end
    end
  end

  assign list_count = 7'(len);

  // element stores
  pal_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_price_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wprice),
    .raddr (raddr),
    .rdata (rprice)
  );

  pal_ram #(.WIDTH(64), .DEPTH(CAPACITY)) u_tag_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wtag),
    .raddr (raddr),
    .rdata (rtag)
  );

  // length stays within the store
  a_len_cap: assert property (@(posedge clk) disable iff (rst) len <= LW'(CAPACITY))
    else $error("list length beyond capacity");

  // a failed command never reports a locate hit
  a_err_nofound: assert property (@(posedge clk) disable iff (rst)
      status |-> (found_position == '0))
    else $error("error status with a found position");

  // a locate hit points inside the list
  a_found_range: assert property (@(posedge clk) disable iff (rst)
      ctrl.set_found |-> (k != '0) && (k <= len))
    else $error("locate hit outside the list");

endmodule

// ===== design/positional_array_list.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_array_list
// Ordered list of up to CAPACITY price/tag elements addressed by 1-based
// position, with get, locate, insert and delete run by a micro program.
//
//   channel   signals                                         beat marked by
//   command   command, position, item_price, item_tag         start && !busy
//   result    status, found_position, out_price, out_tag,     done
//             list_count
//
// Get and errors go straight to the result; locate walks the entries from the
// front until a match or the end, insert shifts entries from the tail down to
// the position, and delete shifts entries from the position up to the tail.
// Each entry walked takes two steps: one read port with a registered read.
// Reset clears the length and the sequencer; store contents stay unknown.
// The result is shown for one cycle with done; the next beat may be taken
// in that same cycle. The receiver cannot stall.
// ----------------------------------------------------------------------------
module positional_array_list #(
  parameter int CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command,
  input  logic [6:0]  position,
  input  logic [31:0] item_price,
  input  logic [63:0] item_tag,
  output logic        done,
  output logic        status,
  output logic [6:0]  found_position,
  output logic [31:0] out_price,
  output logic [63:0] out_tag,
  output logic [6:0]  list_count
);
  logic            launch;
  pal_pkg::ctrl_t  ctrl;
  pal_pkg::flags_t flags;
  logic [6:0]      op_position;
  logic [31:0]     op_price;
  logic [63:0]     op_tag;

  // operand latch for the accepted beat
  always_ff @(posedge clk) begin
    if (launch) begin
      op_position <= position;
      op_price    <= item_price;
      op_tag      <= item_tag;
    end
  end

  // sequencer
  pal_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (command),
    .flags   (flags),
    .launch  (launch),
    .ctrl    (ctrl),
    .busy    (busy),
    .done    (done)
  );

  // datapath and stores
  pal_datapath #(.CAPACITY(CAPACITY)) u_dp (
    .clk            (clk),
    .rst            (rst),
    .launch         (launch),
    .ctrl           (ctrl),
    .op_position    (op_position),
    .op_price       (op_price),
    .op_tag         (op_tag),
    .flags          (flags),
    .status         (status),
    .found_position (found_position),
    .out_price      (out_price),
    .out_tag        (out_tag),
    .list_count     (list_count)
  );

endmodule
